// ===== src/tsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrc_pkg
// Shared types and constants for the timestamp replay cursor.
// ----------------------------------------------------------------------------
package tsrc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int CW          = AW + 1;
  localparam int IDX_W       = 10;
  localparam int POS_BITS    = 16;
  localparam int POS_CW      = $clog2(POS_BITS);

  localparam logic [16:0] RATIO_ONE = 17'd65536;
  localparam logic [15:0] SPEED_MIN = 16'd3;
  localparam logic [15:0] SPEED_RST = 16'd256;
  localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_REWIND = 3'd2,
    OP_SETPL  = 3'd3,
    OP_TOGGLE = 3'd4,
    OP_SEEK   = 3'd5,
    OP_TICK   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_SEEK_ADD, S_SRCH_RD, S_SRCH_CMP,
    S_TK_MUL, S_TK_ADD, S_TK_CHK, S_WALK_RD, S_WALK_CMP,
    S_POS, S_POS_WAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

endpackage

// ===== src/tsrc_ram.sv =====
// ----------------------------------------------------------------------------
// tsrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tsrc_div.sv =====
// ----------------------------------------------------------------------------
// tsrc_div
// Restoring divider producing a Q0.16 ratio num/den, one bit per cycle.
// ----------------------------------------------------------------------------
module tsrc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tsrc_pkg::div_req_t req,
  output logic              done,
  output logic [15:0]       quo
);
  import tsrc_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [POS_CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [63:0]       den_r, den_nxt;
  logic [15:0]       q_r, q_nxt;
  logic [64:0]       sh;

  // one quotient bit per cycle
  always_comb begin
    sh       = {rem_r, 1'b0};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.num;
      den_nxt  = req.den;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 64'(sh - {1'b0, den_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + POS_CW'(1);
      if (cnt_r == POS_CW'(POS_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== src/timestamp_replay_cursor.sv =====
// ----------------------------------------------------------------------------
// timestamp_replay_cursor
// Replay cursor over a table of packet timestamps with seek and tick.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_tready is high only while the sequencer
// is idle and returns in the cycle the result appears on out_tvalid. Clear,
// append, rewind, play control, unknown ops and ignored seeks or ticks go
// from accept to a position check, then wait on the 16-step divider and
// load the output register when the position needs the divider, or load the
// output directly when the position is zero or one. Seek first adds a
// multiply/add phase and binary search steps with one table read each,
// then a closing step. Tick while playing first adds a multiply/add/check
// phase, a step per packet the index walks past with one table read each,
// and closing steps. A finished result sits in the output register; the next item is
// accepted while it waits, but that item's own result holds the sequencer
// until the register has been taken.
module timestamp_replay_cursor (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: play_speed
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  // stamp[63:0], play_flag[64], seek_ratio[81:65], delta_ns[113:82]
  input  logic [119:0] in_tdata,
  // op[2:0]
  input  logic [2:0]   in_tuser,
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // cursor_index[9:0], cursor_time[73:10], is_playing[74], position[91:75]
  output logic [95:0]  out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);
  import tsrc_pkg::*;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [63:0] now_r, now_nxt, first_r, first_nxt, last_r, last_nxt;
  logic               run_r, run_nxt;
  logic [15:0]        spd_r;
  logic [16:0]        ratio_r, ratio_nxt;
  logic [31:0]        delta_r, delta_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [48:0]        prod_r;
  logic [16:0]        pos_r, pos_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               ov_r, ov_nxt;
  logic [95:0]        od_r, od_nxt;
  logic [1:0]         ou_r, ou_nxt;

  logic               in_acc;
  op_t                in_op;
  logic signed [63:0] in_stamp;
  logic [31:0]        mul_a;
  logic [16:0]        mul_b;
  logic [AW-1:0]      raddr;
  logic [63:0]        rdata;
  logic               ram_we;
  div_req_t           dreq;
  logic               div_done;
  logic [15:0]        div_q;
  logic               dir_up;
  logic [63:0]        mag;
  logic [16:0]        ratio_sat;
  logic [15:0]        spd_c;
  logic [CW-1:0]      mid_c;
  logic [AW-1:0]      last_idx;
  logic [CW-1:0]      next_idx;
  logic [63:0]        off;
  logic [64:0]        sum;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_op     = op_t'(in_tuser);
  assign in_stamp  = $signed(in_tdata[63:0]);
  assign cfg_ready = 1'b1;

  // shared helpers
  assign dir_up    = (last_r >= first_r);
  assign mag       = dir_up ? 64'(last_r - first_r) : 64'(first_r - last_r);
  assign ratio_sat = (ratio_r > RATIO_ONE) ? RATIO_ONE : ratio_r;
  assign spd_c     = (spd_r < SPEED_MIN) ? SPEED_MIN : spd_r;
  assign mid_c     = lo_r + ((hi_r - lo_r) >> 1);
  assign last_idx  = AW'(count_r - CW'(1));
  assign next_idx  = {1'b0, idx_r} + CW'(1);
  assign off       = acc_r + {prod_r[47:0], 16'h0000};
  assign sum       = {now_r[63], now_r} + {24'h000000, prod_r[48:8]};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SEEK && count_r != '0) begin
            state_nxt = S_MUL_LO;
          end else if (in_op == OP_TICK && count_r != '0 && run_r) begin
            state_nxt = S_TK_MUL;
          end else begin
            state_nxt = S_POS;
          end
        end
      end
      S_MUL_LO:   state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_SEEK_ADD;
      S_SEEK_ADD: state_nxt = S_SRCH_RD;
      S_SRCH_RD:  state_nxt = (lo_r < hi_r) ? S_SRCH_CMP : S_POS;
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_TK_MUL:   state_nxt = S_TK_ADD;
      S_TK_ADD:   state_nxt = S_TK_CHK;
      S_TK_CHK:   state_nxt = (now_r >= last_r) ? S_POS : S_WALK_RD;
      S_WALK_RD:  state_nxt = (next_idx < count_r) ? S_WALK_CMP : S_POS;
      S_WALK_CMP: state_nxt = ($signed(rdata) <= now_r) ? S_WALK_RD : S_POS;
      S_POS: begin
        if (last_r <= first_r || now_r <= first_r || now_r >= last_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_POS_WAIT;
        end
      end
      S_POS_WAIT: state_nxt = div_done ? S_DONE : S_POS_WAIT;
      S_DONE:     state_nxt = (!ov_r || out_tready) ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // unit controls: multiplier operands, table ports, divider start
  always_comb begin
    mul_a  = delta_r;
    mul_b  = {1'b0, spd_c};
    raddr  = idx_r;
    ram_we = in_acc && in_op == OP_APPEND && count_r < CW'(TABLE_DEPTH);
    dreq.start = 1'b0;
    dreq.num   = 64'(now_r - first_r);
    dreq.den   = 64'(last_r - first_r);
    unique case (state_r)
      S_MUL_LO: begin
        mul_a = mag[31:0];
        mul_b = ratio_sat;
      end
      S_MUL_HI: begin
        mul_a = mag[63:32];
        mul_b = ratio_sat;
      end
      S_SRCH_RD: raddr = mid_c[AW-1:0];
      S_WALK_RD: raddr = next_idx[AW-1:0];
      S_POS: begin
        dreq.start = !(last_r <= first_r || now_r <= first_r || now_r >= last_r);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    now_nxt    = now_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    run_nxt    = run_r;
    ratio_nxt  = ratio_r;
    delta_nxt  = delta_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    // drop the output item once taken
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          ratio_nxt  = in_tdata[81:65];
          delta_nxt  = in_tdata[113:82];
          case (in_op)
            OP_CLEAR: begin
              count_nxt = '0;
              idx_nxt   = '0;
              run_nxt   = 1'b0;
              first_nxt = '0;
              last_nxt  = '0;
              now_nxt   = '0;
            end
            OP_APPEND: begin
              if (count_r < CW'(TABLE_DEPTH)) begin
                count_nxt = count_r + CW'(1);
                idx_nxt   = '0;
                run_nxt   = 1'b0;
                last_nxt  = in_stamp;
                if (count_r == '0) begin
                  first_nxt = in_stamp;
                  now_nxt   = in_stamp;
                end else begin
                  now_nxt = first_r;
                end
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_REWIND: begin
              idx_nxt = '0;
              run_nxt = 1'b0;
              now_nxt = first_r;
            end
            OP_SETPL:  run_nxt = in_tdata[64];
            OP_TOGGLE: run_nxt = !run_r;
            OP_SEEK, OP_TICK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL_HI: acc_nxt = 64'(prod_r >> 16);
      S_SEEK_ADD: begin
        now_nxt = dir_up ? first_r + $signed(off) : first_r - $signed(off);
        lo_nxt  = '0;
        hi_nxt  = count_r;
      end
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_c[AW-1:0];
        end else if (lo_r >= count_r) begin
          idx_nxt = last_idx;
          now_nxt = last_r;
        end else begin
          idx_nxt = lo_r[AW-1:0];
        end
      end
      S_SRCH_CMP: begin
        if ($signed(rdata) < now_r) begin
          lo_nxt = {1'b0, mid_r} + CW'(1);
        end else begin
          hi_nxt = {1'b0, mid_r};
        end
      end
      // saturate at the signed maximum
      S_TK_ADD: now_nxt = (!sum[64] && sum[63]) ? TIME_MAX : $signed(sum[63:0]);
      S_TK_CHK: begin
        if (now_r >= last_r) begin
          now_nxt = last_r;
          idx_nxt = last_idx;
          run_nxt = 1'b0;
        end
      end
      S_WALK_CMP: begin
        if ($signed(rdata) <= now_r) begin
          idx_nxt = next_idx[AW-1:0];
        end
      end
      S_POS: begin
        if (last_r <= first_r || now_r <= first_r) begin
          pos_nxt = '0;
        end else if (now_r >= last_r) begin
          pos_nxt = RATIO_ONE;
        end
      end
      S_POS_WAIT: begin
        if (div_done) begin
          pos_nxt = {1'b0, div_q};
        end
      end
      // load the output register
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {4'h0, pos_r, run_r, now_r, IDX_W'(idx_r)};
          ou_nxt = status_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      now_r   <= '0;
      first_r <= '0;
      last_r  <= '0;
      run_r   <= 1'b0;
      spd_r   <= SPEED_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      now_r   <= now_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      run_r   <= run_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        spd_r <= cfg_data;
      end
    end
    ratio_r  <= ratio_nxt;
    delta_r  <= delta_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    acc_r    <= acc_nxt;
    prod_r   <= mul_a * mul_b;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    od_r     <= od_nxt;
    ou_r     <= ou_nxt;
  end

  tsrc_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_tdata[63:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

// ===== src/tsrc_checker.sv =====
// ----------------------------------------------------------------------------
// tsrc_checker
// Port-level checks for the timestamp replay cursor.
// ----------------------------------------------------------------------------
module tsrc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  // hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output item dropped while stalled");

  // busy after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accept");

  // no output item right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // position stays within one
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[91:75] <= 17'd65536)
    else $error("position above one");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad status");

endmodule

bind timestamp_replay_cursor tsrc_checker u_tsrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
